// ===== rtl/ocl_pkg.sv =====
// ----------------------------------------------------------------------------
// ocl_pkg
// Shared types and constants for the open/closed list engine.
// ----------------------------------------------------------------------------
package ocl_pkg;

  localparam int CFG_BITS = 20;
  localparam logic [CFG_BITS-1:0] MIN_START_RESET = 20'd99999;

  typedef enum logic [2:0] {
    CMD_ADD_OPEN   = 3'd0,
    CMD_ADD_CLOSED = 3'd1,
    CMD_SEARCH     = 3'd2,
    CMD_MIN        = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPEND,
    S_CLEAR,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch a new command
    logic idx_inc;
    logic rd_scan;    // read scan list at idx
    logic rd_shift;   // read scan list at idx+1
    logic wr_shift;   // write read data back at idx
    logic dec_count;  // scan list lost one entry
    logic append;     // append node to target list
    logic clear;      // empty selected list
    logic upd_min;    // fold read entry into running minimum
    logic set_found;
    logic out_load;   // move result into output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_more;
    logic hit;
    logic shift_more;
  } ctl_stat_t;

endpackage

// ===== rtl/ocl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ocl_ctrl
// Command sequencer: scan, shift-down removal, append, clear, and output handshake.
// ----------------------------------------------------------------------------
module ocl_ctrl import ocl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [2:0] in_cmd,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  ctl
);

  state_t state, state_next;
  cmd_t   cmd_q, cmd_q_next;
  logic   out_valid_next;
  logic   is_add;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmd_q     <= CMD_SEARCH;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmd_q     <= cmd_q_next;
      out_valid <= out_valid_next;
    end
  end

  assign is_add = (cmd_q == CMD_ADD_OPEN) || (cmd_q == CMD_ADD_CLOSED);

  always_comb begin
    state_next = state;
    cmd_q_next = cmd_q;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          cmd_q_next = cmd_t'(in_cmd);
          case (cmd_t'(in_cmd))
            CMD_ADD_OPEN, CMD_ADD_CLOSED, CMD_SEARCH, CMD_MIN: state_next = S_SCAN_RD;
            CMD_CLEAR: state_next = S_CLEAR;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_more) begin
          ctl.rd_scan = 1'b1;
          state_next  = S_SCAN_CHK;
        end else if (is_add) begin
          state_next = S_APPEND;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN_CHK: begin
        case (cmd_q)
          CMD_MIN: begin
            ctl.upd_min = 1'b1;
            ctl.idx_inc = 1'b1;
            state_next  = S_SCAN_RD;
          end
          CMD_SEARCH: begin
            if (stat.hit) begin
              ctl.set_found = 1'b1;
              state_next    = S_DONE;
            end else begin
              ctl.idx_inc = 1'b1;
              state_next  = S_SCAN_RD;
            end
          end
          default: begin
            // add: first match is removed by shifting the tail down
            if (stat.hit) begin
              state_next = S_SHIFT_RD;
            end else begin
              ctl.idx_inc = 1'b1;
              state_next  = S_SCAN_RD;
            end
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          ctl.rd_shift = 1'b1;
          state_next   = S_SHIFT_WR;
        end else begin
          ctl.dec_count = 1'b1;
          state_next    = S_APPEND;
        end
      end
      S_SHIFT_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.idx_inc  = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_APPEND: begin
        ctl.append = 1'b1;
        state_next = S_DONE;
      end
      S_CLEAR: begin
        ctl.clear  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (ctl.out_load)           out_valid_next = 1'b1;
  end

endmodule

// ===== rtl/ocl_dp.sv =====
// ----------------------------------------------------------------------------
// ocl_dp
// List memories, counts, scan index, running minimum and result registers.
// ----------------------------------------------------------------------------
module ocl_dp import ocl_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 8,
  parameter int COST_BITS  = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2:0]            in_cmd,
  input  logic                  in_sel,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic [COST_BITS-1:0]  in_cost,
  input  logic                  cfg_we,
  input  logic [CFG_BITS-1:0]   cfg_wdata,
  input  ctl_cmd_t              ctl,
  output ctl_stat_t             stat,
  output logic                  out_found,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic                  out_status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 2 * COORD_BITS + COST_BITS;
  localparam int BW = (COST_BITS > CFG_BITS) ? COST_BITS : CFG_BITS;

  logic [EW-1:0] mem_o [CAPACITY];
  logic [EW-1:0] mem_c [CAPACITY];
  logic [EW-1:0] rd_o, rd_c, rdata, wdata_o, wdata_c;

  logic [COORD_BITS-1:0] x_q, y_q, res_x, res_y;
  logic [COST_BITS-1:0]  cost_q;
  logic                  scan_sel;   // 0 open, 1 closed
  logic [CW-1:0]         idx, open_count, closed_count, scan_cnt, dst_cnt;
  logic [CW:0]           idx_p1;
  logic [BW-1:0]         best;
  logic                  found, status, dst_free;
  logic [CFG_BITS-1:0]   min_start;
  logic [AW-1:0]         raddr, waddr_o, waddr_c;
  logic                  we_o, we_c;
  logic [COORD_BITS-1:0] ent_x, ent_y;
  logic [COST_BITS-1:0]  ent_cost;

  assign idx_p1   = {1'b0, idx} + 1'b1;
  assign raddr    = ctl.rd_shift ? idx_p1[AW-1:0] : idx[AW-1:0];
  assign rdata    = scan_sel ? rd_c : rd_o;
  assign ent_x    = rdata[COORD_BITS-1:0];
  assign ent_y    = rdata[2*COORD_BITS-1:COORD_BITS];
  assign ent_cost = rdata[EW-1:2*COORD_BITS];
  assign scan_cnt = scan_sel ? closed_count : open_count;
  assign dst_cnt  = scan_sel ? open_count : closed_count;
  assign dst_free = dst_cnt < CW'(CAPACITY);

  assign stat.scan_more  = idx < scan_cnt;
  assign stat.hit        = (ent_x == x_q) && (ent_y == y_q);
  assign stat.shift_more = idx_p1 < {1'b0, scan_cnt};

  // append goes to the list opposite the one scanned for removal
  assign we_o    = (ctl.wr_shift && !scan_sel) || (ctl.append && scan_sel && dst_free);
  assign we_c    = (ctl.wr_shift && scan_sel) || (ctl.append && !scan_sel && dst_free);
  assign waddr_o = ctl.append ? open_count[AW-1:0] : idx[AW-1:0];
  assign waddr_c = ctl.append ? closed_count[AW-1:0] : idx[AW-1:0];
  assign wdata_o = ctl.append ? {cost_q, y_q, x_q} : rdata;
  assign wdata_c = wdata_o;

  always_ff @(posedge clk) begin
    if (we_o) mem_o[waddr_o] <= wdata_o;
    if (ctl.rd_scan || ctl.rd_shift) rd_o <= mem_o[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_c) mem_c[waddr_c] <= wdata_c;
    if (ctl.rd_scan || ctl.rd_shift) rd_c <= mem_c[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_start    <= MIN_START_RESET;
      open_count   <= '0;
      closed_count <= '0;
    end else begin
      if (cfg_we) min_start <= cfg_wdata;
      if (ctl.clear || ctl.dec_count) begin
        if (scan_sel) closed_count <= ctl.clear ? '0 : closed_count - 1'b1;
        else          open_count   <= ctl.clear ? '0 : open_count - 1'b1;
      end
      if (ctl.append && dst_free) begin
        if (scan_sel) open_count   <= open_count + 1'b1;
        else          closed_count <= closed_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_q    <= in_x;
      y_q    <= in_y;
      cost_q <= in_cost;
      case (cmd_t'(in_cmd))
        CMD_ADD_OPEN:   scan_sel <= 1'b1;
        CMD_ADD_CLOSED: scan_sel <= 1'b0;
        default:        scan_sel <= in_sel;
      endcase
      idx    <= '0;
      best   <= BW'(min_start);
      found  <= 1'b0;
      status <= 1'b0;
      res_x  <= '0;
      res_y  <= '0;
    end else begin
      if (ctl.idx_inc) idx <= idx + 1'b1;
      if (ctl.set_found) found <= 1'b1;
      if (ctl.append && !dst_free) status <= 1'b1;
      // strict compare keeps the earliest entry on equal cost
      if (ctl.upd_min && (BW'(ent_cost) < best)) begin
        best  <= BW'(ent_cost);
        found <= 1'b1;
        res_x <= ent_x;
        res_y <= ent_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_found  <= found;
      out_x      <= res_x;
      out_y      <= res_y;
      out_status <= status;
    end
  end

endmodule

// ===== rtl/open_closed_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// open_closed_list_engine_core
// Open/closed node lists for grid path search with add, search, min, clear.
// ----------------------------------------------------------------------------
// One command at a time; each list memory has one registered read port, so a
// scan or a removal handles the entries one after another. The next command
// is accepted once the result is in the output register; a result waiting on
// m_tready holds the block in its last state.
// Reset clears both counts and loads min_start with 99999; lists stay undefined.
module open_closed_list_engine_core import ocl_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 8,
  parameter int COST_BITS  = 20
) (
  input  logic clk,
  input  logic rst,
  // x, y, cost
  input  logic [((2*COORD_BITS+COST_BITS+7)/8)*8-1:0] s_tdata,
  // cmd[2:0], list_sel
  input  logic [3:0] s_tuser,
  input  logic       s_tvalid,
  output logic       s_tready,
  // out_x, out_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  // found, status
  output logic [1:0] m_tuser,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int ODW = ((2*COORD_BITS+7)/8)*8;

  ctl_cmd_t  ctl;
  ctl_stat_t stat;
  logic                  out_found, out_status;
  logic [COORD_BITS-1:0] out_x, out_y;

  ocl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_cmd    (s_tuser[2:0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  ocl_dp #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS),
    .COST_BITS  (COST_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (s_tuser[2:0]),
    .in_sel     (s_tuser[3]),
    .in_x       (s_tdata[COORD_BITS-1:0]),
    .in_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_cost    (s_tdata[2*COORD_BITS+COST_BITS-1:2*COORD_BITS]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ctl        (ctl),
    .stat       (stat),
    .out_found  (out_found),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_status (out_status)
  );

  assign m_tdata = ODW'({out_y, out_x});
  assign m_tuser = {out_status, out_found};

  // one command in flight: no transfer right after an accepted one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a command is in progress");

  // found comes from search/min, status only from an add
  a_found_status_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("found and status both set");

  a_coords_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("coordinates nonzero without a found entry");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the open/closed list engine. A scoreboard class
// keeps its own copy of both node lists and the minimum bound, predicts one
// response per accepted command and compares every response field by field.
// A short directed sequence is followed by random phases with different
// minimum bounds, a list-filling phase and stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_top import ocl_pkg::*; ();

  localparam int CAPACITY    = 64;
  localparam int COORD_BITS  = 8;
  localparam int COST_BITS   = 20;
  localparam int TDATA_W     = ((2*COORD_BITS+COST_BITS+7)/8)*8;
  localparam int MDATA_W     = ((2*COORD_BITS+7)/8)*8;
  localparam logic LIST_OPEN   = 1'b0;
  localparam logic LIST_CLOSED = 1'b1;
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AT     = 320;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE      = 300;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COST_BITS-1:0]  cost_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    cost_t  cost;
  } node_t;

  typedef struct packed {
    logic   found;
    coord_t ox;
    coord_t oy;
    logic   status;
  } response_t;

  // --------------------------------------------------------------------------
  class list_scoreboard;
    node_t       lists[2][$];
    cost_t       min_bound;
    response_t   pending[$];
    int n_in, n_out, n_err;
    int n_search_hit, n_min_hit, n_removed, n_full, n_clear;

    function new();
      min_bound = MIN_START_RESET;
    endfunction

    function int find_node(int which, coord_t fx, coord_t fy);
      for (int i = 0; i < lists[which].size(); i++)
        if (lists[which][i].x == fx && lists[which][i].y == fy) return i;
      return -1;
    endfunction

    function void note_command(logic [2:0] cmd, logic sel, coord_t nx, coord_t ny,
                               cost_t ncost);
      response_t r;
      int tgt;
      int idx;
      cost_t best;
      r = '0;
      n_in++;
      case (cmd)
        CMD_ADD_OPEN, CMD_ADD_CLOSED: begin
          tgt = (cmd == CMD_ADD_OPEN) ? int'(LIST_OPEN) : int'(LIST_CLOSED);
          // node leaves the other list even when the append is dropped
          idx = find_node(1 - tgt, nx, ny);
          if (idx >= 0) begin
            lists[1 - tgt].delete(idx);
            n_removed++;
          end
          if (lists[tgt].size() >= CAPACITY) begin
            r.status = 1'b1;
            n_full++;
          end else begin
            lists[tgt].push_back('{x: nx, y: ny, cost: ncost});
          end
        end
        CMD_SEARCH: begin
          r.found = (find_node(int'(sel), nx, ny) >= 0);
          if (r.found) n_search_hit++;
        end
        CMD_MIN: begin
          best = min_bound;
          for (int i = 0; i < lists[sel].size(); i++) begin
            if (lists[sel][i].cost < best) begin
              best    = lists[sel][i].cost;
              r.found = 1'b1;
              r.ox    = lists[sel][i].x;
              r.oy    = lists[sel][i].y;
            end
          end
          if (r.found) n_min_hit++;
        end
        CMD_CLEAR: begin
          lists[sel].delete();
          n_clear++;
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(response_t got);
      response_t exp_r;
      n_out++;
      if (pending.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("[%0t] unexpected response: found=%0d x=%0d y=%0d status=%0d",
                   $time, got.found, got.ox, got.oy, got.status);
        return;
      end
      exp_r = pending.pop_front();
      if (got.found !== exp_r.found || got.ox !== exp_r.ox ||
          got.oy !== exp_r.oy || got.status !== exp_r.status) begin
        n_err++;
        if (n_err <= 10)
          $display("[%0t] response %0d mismatch: exp found=%0d x=%0d y=%0d status=%0d",
                   $time, n_out, exp_r.found, exp_r.ox, exp_r.oy, exp_r.status,
                   " | got found=%0d x=%0d y=%0d status=%0d",
                   got.found, got.ox, got.oy, got.status);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [TDATA_W-1:0]  s_tdata = '0;
  logic [3:0]          s_tuser = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [MDATA_W-1:0]  m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  list_scoreboard sb;
  int cycles = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int rx_mode = 0;
  int rx_left = 0;

  open_closed_list_engine_core #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS),
    .COST_BITS (COST_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               sb.pending.size());
      $display("status: fail");
      $finish;
    end
  end

  // one long receiver hold-off while the sender keeps offering commands
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && sb.n_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: check every transfer, stall on a mode pattern of its own
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result('{found: m_tuser[0], ox: m_tdata[7:0], oy: m_tdata[15:8],
                          status: m_tuser[1]});
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      if (hold_left > 0)
        m_tready <= 1'b0;
      else if (rx_mode == 0)
        m_tready <= 1'b1;
      else if (rx_mode == 1)
        m_tready <= ($urandom_range(0, 3) != 0);
      else
        m_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  // --------------------------------------------------------------------------
  task automatic send_cmd(input logic [2:0] cmd, input logic sel, input coord_t nx,
                          input coord_t ny, input cost_t ncost);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W-2*COORD_BITS-COST_BITS){1'b0}}, ncost, ny, nx};
    s_tuser  <= {sel, cmd};
    do @(posedge clk); while (!s_tready);
    sb.note_command(cmd, sel, nx, ny, ncost);
  endtask

  // sender pauses until every response is back, block is then idle
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_min_bound(input cost_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.min_bound = v;
  endtask

  task automatic pick_xy(output coord_t px, output coord_t py);
    int r;
    int which;
    int n;
    node_t nd;
    r     = $urandom_range(0, 99);
    which = $urandom_range(0, 1);
    n     = sb.lists[which].size();
    if (r < 45 && n > 0) begin
      nd = sb.lists[which][$urandom_range(0, n - 1)];
      px = nd.x;
      py = nd.y;
    end else if (r < 80) begin
      px = coord_t'($urandom_range(0, 7));
      py = coord_t'($urandom_range(0, 7));
    end else begin
      px = coord_t'($urandom);
      py = coord_t'($urandom);
    end
  endtask

  function automatic cost_t pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return cost_t'($urandom_range(0, 3));
    if (r < 55) return sb.min_bound + cost_t'($urandom_range(0, 4)) - cost_t'(2);
    return cost_t'($urandom);
  endfunction

  task automatic random_cmds(input int count, input int add_pct, input int open_pct,
                             input int clear_pct);
    int r;
    logic [2:0] cmd;
    coord_t px, py;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct)
        cmd = ($urandom_range(0, 99) < open_pct) ? CMD_ADD_OPEN : CMD_ADD_CLOSED;
      else if (r < add_pct + clear_pct)
        cmd = CMD_CLEAR;
      else if (r < add_pct + clear_pct + 2)
        cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      else
        cmd = $urandom_range(0, 1) ? CMD_SEARCH : CMD_MIN;
      pick_xy(px, py);
      send_cmd(cmd, 1'($urandom_range(0, 1)), px, py, pick_cost());
    end
  endtask

  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty lists, extremes, node at origin, moves, ties, clears
    send_cmd(CMD_MIN,        LIST_OPEN,   8'd0,   8'd0,   20'd0);
    send_cmd(CMD_SEARCH,     LIST_OPEN,   8'd0,   8'd0,   20'd0);
    send_cmd(CMD_ADD_OPEN,   LIST_OPEN,   8'd0,   8'd0,   20'd0);
    send_cmd(CMD_ADD_OPEN,   LIST_CLOSED, 8'hFF,  8'hFF,  20'hFFFFF);
    send_cmd(CMD_ADD_OPEN,   LIST_OPEN,   8'hAA,  8'h55,  20'd99998);
    send_cmd(CMD_ADD_OPEN,   LIST_OPEN,   8'h55,  8'hAA,  20'd99999);
    send_cmd(CMD_MIN,        LIST_OPEN,   8'd0,   8'd0,   20'd0);
    send_cmd(CMD_SEARCH,     LIST_OPEN,   8'hFF,  8'hFF,  20'd0);
    send_cmd(CMD_SEARCH,     LIST_CLOSED, 8'hFF,  8'hFF,  20'd0);
    send_cmd(CMD_ADD_CLOSED, LIST_OPEN,   8'd0,   8'd0,   20'd7);
    send_cmd(CMD_MIN,        LIST_OPEN,   8'd0,   8'd0,   20'd0);
    send_cmd(CMD_ADD_CLOSED, LIST_CLOSED, 8'd0,   8'd0,   20'd7);
    send_cmd(CMD_ADD_CLOSED, LIST_CLOSED, 8'h12,  8'h34,  20'd7);
    send_cmd(CMD_SEARCH,     LIST_CLOSED, 8'd0,   8'd0,   20'hFFFFF);
    send_cmd(CMD_ADD_OPEN,   LIST_CLOSED, 8'd0,   8'd0,   20'd3);
    // equal costs: the earlier closed entry wins
    send_cmd(CMD_MIN,        LIST_CLOSED, 8'hFF,  8'hFF,  20'd0);
    send_cmd(CMD_CLEAR,      LIST_CLOSED, 8'hFF,  8'hFF,  20'hFFFFF);
    send_cmd(CMD_MIN,        LIST_CLOSED, 8'd0,   8'd0,   20'd0);
    send_cmd(CMD_SEARCH,     LIST_CLOSED, 8'd0,   8'd0,   20'd0);
    send_cmd(CMD_UNUSED_FIRST, LIST_CLOSED, 8'hFF, 8'hFF, 20'hFFFFF);
    send_cmd(CMD_UNUSED_MID, LIST_OPEN,   8'h0F,  8'hF0,  20'h5A5A5);
    send_cmd(CMD_UNUSED_LAST, LIST_OPEN,  8'd0,   8'd0,   20'd0);
    send_cmd(CMD_SEARCH,     LIST_OPEN,   8'hAA,  8'h55,  20'd0);
    send_cmd(CMD_CLEAR,      LIST_OPEN,   8'd0,   8'd0,   20'd0);
    send_cmd(CMD_MIN,        LIST_OPEN,   8'd0,   8'd0,   20'd0);

    // fill phase: open list overflows, appends get dropped
    write_min_bound(20'hFFFFF);
    random_cmds(150, 85, 85, 0);
    write_min_bound(20'd0);
    random_cmds(100, 50, 55, 3);
    write_min_bound(20'd1);
    random_cmds(100, 50, 50, 3);
    write_min_bound(cost_t'($urandom));
    random_cmds(100, 50, 50, 4);
    write_min_bound(MIN_START_RESET);
    random_cmds(100, 55, 45, 2);

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("ran %0d commands, %0d responses, %0d mismatches", sb.n_in, sb.n_out,
             sb.n_err);
    $display("search hits %0d, min hits %0d, moves %0d, dropped appends %0d, clears %0d",
             sb.n_search_hit, sb.n_min_hit, sb.n_removed, sb.n_full, sb.n_clear);
    if (sb.n_err == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
